/* rtl/ttec_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ttec_pkg
// Shared constants, types and the LFO tap displacement table for the
// three-tap ensemble chorus.
// ----------------------------------------------------------------------------
package ttec_pkg;

   localparam int DELAY_DEPTH = 1024;
   localparam int WAVE_LENGTH = 735;
   localparam int SWING_RANGE = 100;

   localparam int ADDR_W    = $clog2(DELAY_DEPTH);
   localparam int PHASE_W   = $clog2(WAVE_LENGTH);
   localparam int SAMPLE_W  = 16;
   localparam int OUT_W     = 15;
   localparam int CPS_W     = 16;
   localparam int ACC_W     = SAMPLE_W + 2;
   localparam int DIV_SHIFT = ACC_W - 1;
   localparam int FLIGHT_W  = 2;

   localparam logic [CPS_W-1:0]     CPS_RESET     = CPS_W'(3);
   localparam logic [PHASE_W-1:0]   PHASE_A_RESET = '0;
   localparam logic [PHASE_W-1:0]   PHASE_B_RESET = PHASE_W'(WAVE_LENGTH / 3);
   localparam logic [PHASE_W-1:0]   PHASE_C_RESET = PHASE_W'((2 * WAVE_LENGTH) / 3);
   localparam logic [PHASE_W-1:0]   PHASE_LAST    = PHASE_W'(WAVE_LENGTH - 1);
   localparam logic [FLIGHT_W-1:0]  MAX_FLIGHT    = FLIGHT_W'(2);
   localparam logic [DIV_SHIFT-1:0] RECIP_3       = DIV_SHIFT'((2 ** DIV_SHIFT) / 3 + 1);

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1073741824;
   localparam longint unsigned ROUND_DEN   = 6 * ONE_Q30;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_READ_A,
      SEQ_READ_B,
      SEQ_READ_C
   } seq_state_type;

   typedef logic [ADDR_W-1:0] disp_table_type [WAVE_LENGTH];

   function automatic longint sine_q30(int unsigned pos);
      int unsigned q;
      int unsigned quad;
      int unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint sum;
      q    = 4 * pos;
      quad = q / WAVE_LENGTH;
      r    = q % WAVE_LENGTH;
      if (quad[0]) begin
         r = WAVE_LENGTH - r;
      end
      x    = (longint'(r) * HALF_PI_Q30) / WAVE_LENGTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 210;
      sum  = sum - longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      return (quad >= 2) ? -sum : sum;
   endfunction

   // Entry holds half the store plus the LFO offset, wrapped to the store.
   function automatic disp_table_type build_disp_table();
      disp_table_type  tbl;
      longint          s1;
      longint          s2;
      longint          num;
      longint unsigned mag;
      longint          ent;
      for (int i = 0; i < WAVE_LENGTH; i++) begin
         s1  = sine_q30(i);
         s2  = sine_q30((10 * i) % WAVE_LENGTH);
         num = 3 * longint'(SWING_RANGE) * s1 + 2 * longint'(SWING_RANGE) * s2;
         mag = (num < 0) ? longint'(-num) : longint'(num);
         ent = longint'((mag + ROUND_DEN / 2) / ROUND_DEN);
         if (num < 0) begin
            ent = -ent;
         end
         tbl[i] = ADDR_W'(longint'(DELAY_DEPTH / 2) + ent);
      end
      return tbl;
   endfunction

   localparam disp_table_type DISP_TABLE = build_disp_table();

endpackage
`default_nettype wire

/* rtl/three_tap_ensemble_chorus_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// three_tap_ensemble_chorus_unit
// Three-tap modulated delay chorus. Each sample is halved and written into a
// 1024-entry delay RAM; three LFO-displaced taps are read back and averaged.
//
// Usage:
//   req_* carries one signed audio sample per transfer, rsp_* one averaged
//   sample per transfer; both use valid/stall, stall driven by the receiver.
//   csr_wr_en/csr_wr_data write counts_per_step; write only while idle.
//   A new sample is taken no sooner than the last tap read of the one before,
//   set by the single RAM read port that serves the three taps in turn. The
//   write of the next sample shares the cycle of the last tap read.
//   Taps read in READ_A/B/C are summed in sum_ff, then registered in out_ff.
//   Reset clears pointers, phases and counters at once; no clearing pass.
//   A fill count marks the RAM entries never written, and those read as zero.
//   When rsp_stall holds a result, one more sample may be taken and finished;
//   then req_stall rises until the output drains. No transfer is lost.
// ----------------------------------------------------------------------------
module three_tap_ensemble_chorus_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [ttec_pkg::SAMPLE_W-1:0] req_sample_in,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [ttec_pkg::OUT_W-1:0]         rsp_sample_out,
   input  wire logic                                 csr_wr_en,
   input  wire logic [ttec_pkg::CPS_W-1:0]           csr_wr_data
);
   import ttec_pkg::*;

   seq_state_type state_ff, state_in;

   logic [ADDR_W-1:0]   wp_ff, wp_in;
   logic [PHASE_W-1:0]  phase_a_ff, phase_a_in;
   logic [PHASE_W-1:0]  phase_b_ff, phase_b_in;
   logic [PHASE_W-1:0]  phase_c_ff, phase_c_in;
   logic [CPS_W-1:0]    rate_ff, rate_in;
   logic [CPS_W-1:0]    cps_ff, cps_in;
   logic [ADDR_W:0]     fill_ff, fill_in;
   logic [FLIGHT_W-1:0] flight_ff, flight_in;
   logic [CPS_W:0]      rate_next;
   logic                lfo_step;
   logic [PHASE_W-1:0]  phase_a_adv;
   logic [PHASE_W-1:0]  phase_b_adv;
   logic [PHASE_W-1:0]  phase_c_adv;

   logic req_xfer;
   logic rsp_xfer;
   logic seq_open;
   logic room;

   logic [PHASE_W-1:0] disp_phase;
   logic [ADDR_W-1:0]  disp_ff, disp_in;
   logic [ADDR_W-1:0]  rd_addr;
   logic               rd_en;
   logic               rd_first;
   logic               rd_last;
   logic               rd_ok;

   logic tap_live_ff, tap_first_ff, tap_last_ff, tap_ok_ff;

   logic [SAMPLE_W:0]          half_wide;
   logic [SAMPLE_W-1:0]        wr_data;
   logic [SAMPLE_W-1:0]        rd_data;
   logic signed [SAMPLE_W-1:0] tap_data;
   logic signed [ACC_W-1:0]    tap_ext;

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] sum_ff, sum_in;
   logic                    sum_valid_ff, sum_valid_in;
   logic                    sum_move;

   logic [ACC_W-1:0]         neg_sum;
   logic [DIV_SHIFT-1:0]     sum_mag;
   logic [DIV_SHIFT-1:0]     div_arg;
   logic [2*DIV_SHIFT-1:0]   div_prod;
   logic [DIV_SHIFT-1:0]     quot;
   logic [ACC_W-1:0]         res;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] out_ff;

   // ---- handshake ----
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign seq_open  = (state_ff == SEQ_IDLE) || (state_ff == SEQ_READ_C);
   assign room      = (flight_ff < MAX_FLIGHT) || rsp_xfer;
   assign req_stall = !(seq_open && room);
   assign req_xfer  = req_valid && !req_stall;

   // ---- LFO phase advance ----
   assign rate_next   = {1'b0, rate_ff} + (CPS_W+1)'(1);
   assign lfo_step    = rate_next > {1'b0, cps_ff};
   assign phase_a_adv = !lfo_step ? phase_a_ff :
                        (phase_a_ff == PHASE_LAST) ? '0 : phase_a_ff + PHASE_W'(1);
   assign phase_b_adv = !lfo_step ? phase_b_ff :
                        (phase_b_ff == PHASE_LAST) ? '0 : phase_b_ff + PHASE_W'(1);
   assign phase_c_adv = !lfo_step ? phase_c_ff :
                        (phase_c_ff == PHASE_LAST) ? '0 : phase_c_ff + PHASE_W'(1);

   // ---- sequencer ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      disp_phase = phase_a_adv;
      rd_en      = 1'b0;
      rd_first   = 1'b0;
      rd_last    = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: begin
            state_in = req_xfer ? SEQ_READ_A : SEQ_IDLE;
         end
         SEQ_READ_A: begin
            disp_phase = phase_b_ff;
            rd_en      = 1'b1;
            rd_first   = 1'b1;
            state_in   = SEQ_READ_B;
         end
         SEQ_READ_B: begin
            disp_phase = phase_c_ff;
            rd_en      = 1'b1;
            state_in   = SEQ_READ_C;
         end
         SEQ_READ_C: begin
            rd_en    = 1'b1;
            rd_last  = 1'b1;
            state_in = req_xfer ? SEQ_READ_A : SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // ---- pointer, phase, fill and configuration state ----
   always_comb begin
      wp_in      = wp_ff;
      phase_a_in = phase_a_ff;
      phase_b_in = phase_b_ff;
      phase_c_in = phase_c_ff;
      rate_in    = rate_ff;
      fill_in    = fill_ff;
      cps_in     = csr_wr_en ? csr_wr_data : cps_ff;
      flight_in  = flight_ff + FLIGHT_W'(req_xfer) - FLIGHT_W'(rsp_xfer);
      if (req_xfer) begin
         wp_in      = wp_ff + ADDR_W'(1);
         fill_in    = fill_ff[ADDR_W] ? fill_ff : fill_ff + (ADDR_W+1)'(1);
         phase_a_in = phase_a_adv;
         phase_b_in = phase_b_adv;
         phase_c_in = phase_c_adv;
         rate_in    = lfo_step ? '0 : rate_next[CPS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         phase_a_ff <= PHASE_A_RESET;
         phase_b_ff <= PHASE_B_RESET;
         phase_c_ff <= PHASE_C_RESET;
         rate_ff    <= '0;
         cps_ff     <= CPS_RESET;
         fill_ff    <= '0;
         flight_ff  <= '0;
      end else begin
         wp_ff      <= wp_in;
         phase_a_ff <= phase_a_in;
         phase_b_ff <= phase_b_in;
         phase_c_ff <= phase_c_in;
         rate_ff    <= rate_in;
         cps_ff     <= cps_in;
         fill_ff    <= fill_in;
         flight_ff  <= flight_in;
      end
   end

   // ---- tap displacement, registered in the cycle before each read ----
   assign disp_in = DISP_TABLE[disp_phase];

   always_ff @(posedge clock) begin
      disp_ff <= disp_in;
   end

   // ---- delay RAM ----
   assign half_wide = {req_sample_in[SAMPLE_W-1], req_sample_in}
                    + (SAMPLE_W+1)'(req_sample_in[SAMPLE_W-1]);
   assign wr_data   = half_wide[SAMPLE_W:1];

   assign rd_addr = wp_ff + disp_ff;
   assign rd_ok   = fill_ff[ADDR_W] || ((rd_addr != '0) && ({1'b0, rd_addr} <= fill_ff));

   ttec_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (DELAY_DEPTH)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (req_xfer),
      .wr_addr (wp_ff + ADDR_W'(1)),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_live_ff <= 1'b0;
      end else begin
         tap_live_ff <= rd_en;
      end
      tap_first_ff <= rd_first;
      tap_last_ff  <= rd_last;
      tap_ok_ff    <= rd_ok;
   end

   // ---- accumulate taps ----
   assign tap_data = tap_ok_ff ? signed'(rd_data) : '0;
   assign tap_ext  = ACC_W'(tap_data);
   assign sum_move = sum_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      sum_valid_in = sum_move ? 1'b0 : sum_valid_ff;
      if (tap_live_ff) begin
         acc_in = tap_first_ff ? tap_ext : acc_ff + tap_ext;
         if (tap_last_ff) begin
            sum_in       = acc_ff + tap_ext;
            sum_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= sum_valid_in;
      end
      acc_ff <= acc_in;
      sum_ff <= sum_in;
   end

   // ---- divide by three, round half away from zero ----
   assign neg_sum  = -sum_ff;
   assign sum_mag  = sum_ff[ACC_W-1] ? neg_sum[DIV_SHIFT-1:0] : sum_ff[DIV_SHIFT-1:0];
   assign div_arg  = sum_mag + DIV_SHIFT'(1);
   assign div_prod = {{DIV_SHIFT{1'b0}}, div_arg} * {{DIV_SHIFT{1'b0}}, RECIP_3};
   assign quot     = div_prod[2*DIV_SHIFT-1:DIV_SHIFT];
   assign res      = sum_ff[ACC_W-1] ? -{1'b0, quot} : {1'b0, quot};

   // ---- output register ----
   assign rsp_valid_in = sum_move ? 1'b1 : (rsp_xfer ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (sum_move) begin
         out_ff <= signed'(res[OUT_W-1:0]);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = out_ff;

endmodule
`default_nettype wire

/* rtl/ttec_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ttec_ram
// Simple dual-port RAM: one write port, one read port with registered
// read data. A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module ttec_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* tb/tb_three_tap_ensemble_chorus_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_three_tap_ensemble_chorus_unit
// Self-checking bench for the three-tap ensemble chorus. A local model of the
// delay line, the LFO table and the phase stepping predicts every averaged
// sample. Each rsp transfer is checked in order against the oldest prediction.
// Directed samples come first, then random segments at several LFO rates.
// Both sides insert random idle bursts, except in the last part of the run.
// ----------------------------------------------------------------------------
module tb_three_tap_ensemble_chorus_unit;

   localparam int DEPTH      = ttec_pkg::DELAY_DEPTH;
   localparam int WAVE       = ttec_pkg::WAVE_LENGTH;
   localparam int SWING      = ttec_pkg::SWING_RANGE;
   localparam int SW         = ttec_pkg::SAMPLE_W;
   localparam int OW         = ttec_pkg::OUT_W;
   localparam int CW         = ttec_pkg::CPS_W;
   localparam int AW         = ttec_pkg::ADDR_W;
   localparam int SETTLE     = 12;
   localparam int DOG_LIMIT  = 1000;
   localparam int MAX_REPORT = 10;
   localparam logic [CW-1:0] CPS_AT_RESET = CW'(3);

   localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
   localparam longint unsigned Q30_ONE     = 64'd1073741824;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [SW-1:0] req_sample_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [OW-1:0] rsp_sample_out;
   logic                 csr_wr_en;
   logic [CW-1:0]        csr_wr_data;

   three_tap_ensemble_chorus_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // model state
   logic signed [SW-1:0] delay_line [DEPTH];
   int                   lfo_offset [WAVE];
   logic [AW-1:0]        wr_ptr;
   int unsigned          phase_a;
   int unsigned          phase_b;
   int unsigned          phase_c;
   int unsigned          rate_cnt;
   logic [CW-1:0]        step_count;

   logic signed [OW-1:0] pending_mix [$];
   int                   mismatch_count;
   bit                   idle_on;
   int                   stall_left;
   int                   dog_cycles;
   int                   seg_left;
   int                   seg_mode;

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint sine_fixed(int unsigned pos);
      int unsigned     quad;
      int unsigned     r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      quad = (4 * pos) / WAVE;
      r    = (4 * pos) % WAVE;
      if (quad % 2 == 1) begin
         r = WAVE - r;
      end
      x    = (longint'(r) * Q30_HALF_PI) / longint'(WAVE);
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
         term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      return (quad >= 2) ? -acc : acc;
   endfunction

   task automatic reset_model();
      longint          num;
      longint unsigned mag;
      longint unsigned den;
      longint          ent;
      den = 6 * Q30_ONE;
      for (int i = 0; i < WAVE; i++) begin
         num = 3 * longint'(SWING) * sine_fixed(i)
             + 2 * longint'(SWING) * sine_fixed((10 * i) % WAVE);
         mag = (num < 0) ? longint'(-num) : longint'(num);
         ent = longint'((mag + den / 2) / den);
         lfo_offset[i] = (num < 0) ? int'(-ent) : int'(ent);
      end
      for (int i = 0; i < DEPTH; i++) begin
         delay_line[i] = '0;
      end
      wr_ptr     = '0;
      phase_a    = 0;
      phase_b    = WAVE / 3;
      phase_c    = (2 * WAVE) / 3;
      rate_cnt   = 0;
      step_count = CPS_AT_RESET;
   endtask

   function automatic int unsigned next_phase(int unsigned p);
      return (p + 1 >= WAVE) ? 0 : p + 1;
   endfunction

   function automatic int tap_value(int unsigned phase);
      logic [AW-1:0] idx;
      idx = AW'(int'(wr_ptr) + DEPTH / 2 + lfo_offset[phase]);
      return int'(delay_line[idx]);
   endfunction

   function automatic logic signed [OW-1:0] chorus_predict(logic signed [SW-1:0] s);
      int          sum;
      int unsigned mag;
      int unsigned q;
      int          res;
      wr_ptr             = wr_ptr + 1'b1;
      delay_line[wr_ptr] = SW'(int'(s) / 2);
      rate_cnt           = rate_cnt + 1;
      if (rate_cnt > int'(step_count)) begin
         phase_a  = next_phase(phase_a);
         phase_b  = next_phase(phase_b);
         phase_c  = next_phase(phase_c);
         rate_cnt = 0;
      end
      sum = tap_value(phase_a) + tap_value(phase_b) + tap_value(phase_c);
      mag = (sum < 0) ? -sum : sum;
      q   = (2 * mag + 3) / 6;
      res = (sum < 0) ? -int'(q) : int'(q);
      return OW'(res);
   endfunction

   task automatic send_sample(input logic signed [SW-1:0] s);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= s;
      do @(posedge clock); while (req_stall);
      pending_mix.push_back(chorus_predict(s));
   endtask

   // hold off until every predicted sample has drained out of the block
   task automatic drain_block();
      req_valid <= 1'b0;
      while (pending_mix.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_step_count(input logic [CW-1:0] v);
      drain_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      step_count = v;
   endtask

   function automatic logic signed [SW-1:0] random_sample();
      if (seg_left == 0) begin
         seg_left = $urandom_range(1, 64);
         seg_mode = $urandom_range(0, 3);
      end
      seg_left--;
      case (seg_mode)
         0: begin
            return SW'($urandom);
         end
         1: begin
            case ($urandom_range(0, 3))
               0:       return 16'sh7fff;
               1:       return 16'sh8000;
               2:       return 16'sh7ffe;
               default: return 16'sh8001;
            endcase
         end
         2: begin
            return SW'($urandom_range(0, 8) - 4);
         end
         default: begin
            return (seg_left % 2 == 0) ? SW'($urandom_range(24576, 32767))
                                       : SW'(-$urandom_range(24576, 32768));
         end
      endcase
   endfunction

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         send_sample(random_sample());
      end
   endtask

   task automatic test_field_extremes();
      logic signed [SW-1:0] pattern [14];
      pattern = '{16'sh7fff, 16'sh8000, 16'sh0000, -16'sd1, 16'sd1, -16'sd2, -16'sd3,
                  16'sd2, 16'sd3, 16'sh4000, -16'sd16385, 16'sh5555, 16'shaaaa,
                  16'sh8001};
      foreach (pattern[i]) begin
         send_sample(pattern[i]);
      end
   endtask

   task automatic test_rate_lowered();
      write_step_count(CW'(40));
      for (int i = 0; i < 8; i++) begin
         send_sample(SW'($urandom));
      end
      write_step_count(CW'(1));
      send_sample(SW'($urandom));
      send_sample(SW'($urandom));
   endtask

   task automatic test_fast_lfo();
      write_step_count('0);
      send_random(300);
   endtask

   task automatic test_frozen_lfo();
      write_step_count('1);
      send_random(120);
   endtask

   task automatic test_random_rate();
      for (int k = 0; k < 3; k++) begin
         if (k == 2) begin
            write_step_count(CW'($urandom));
         end else begin
            write_step_count(CW'($urandom_range(1, 20)));
         end
         send_random(60);
      end
   endtask

   task automatic test_steady_stream();
      write_step_count(CPS_AT_RESET);
      idle_on = 1'b0;
      send_random(150);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
         stall_left = $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_mix.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORT) begin
               $display("unexpected sample_out %0d", rsp_sample_out);
            end
         end else begin
            if (rsp_sample_out !== pending_mix[0]) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORT) begin
                  $display("sample_out mismatch: expected %0d actual %0d",
                           pending_mix[0], rsp_sample_out);
               end
            end
            void'(pending_mix.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         dog_cycles = 0;
      end else begin
         dog_cycles++;
         if (dog_cycles >= DOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_sample_in  = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      rsp_stall      = 1'b0;
      mismatch_count = 0;
      idle_on        = 1'b1;
      seg_left       = 0;
      seg_mode       = 0;
      dog_cycles     = 0;
      reset_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_rate_lowered();
      test_fast_lfo();
      test_frozen_lfo();
      test_random_rate();
      test_steady_stream();
      drain_block();
      if (mismatch_count == 0 && pending_mix.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* three_tap_ensemble_chorus_unit.f */
rtl/ttec_pkg.sv
rtl/ttec_ram.sv
rtl/three_tap_ensemble_chorus_unit.sv
tb/tb_three_tap_ensemble_chorus_unit.sv
